>>> hdl/reno_congestion_window_control_core_assert.svh
// Assertion macros for the Reno congestion window control core.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef RENO_CONGESTION_WINDOW_CONTROL_CORE_ASSERT_SVH
`define RENO_CONGESTION_WINDOW_CONTROL_CORE_ASSERT_SVH

// Generic clocked assertion with active-low reset gating.
`define RCWC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand on the core clock and reset.
`define RCWC_ASSERT(label, prop, msg) \
    `RCWC_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

>>> hdl/rcwc_pkg.sv
// Shared types and constants for the Reno congestion window control core.
// No dependencies; used by the interfaces, the arithmetic unit and the top level.
package rcwc_pkg;

    localparam int unsigned SEQ_W     = 32;
    localparam int unsigned WIN_W     = 16;
    localparam int unsigned AVOID_W   = 18;
    localparam int unsigned ALU_W     = SEQ_W + 1;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [WIN_W-1:0] MAX_WINDOW_RST = 16'd16384;
    localparam logic [WIN_W-1:0] INIT_THR_RST   = 16'd128;
    localparam int unsigned      DUP_ACK_LIMIT_DEF = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR   = 1'b1;

    localparam logic [1:0] INC_ONE   = 2'd1;
    localparam logic [1:0] INC_THREE = 2'd3;

    typedef enum logic {
        OP_ACK     = 1'b0,
        OP_TIMEOUT = 1'b1
    } t_operation;

    typedef enum logic [1:0] {
        PH_SLOW    = 2'd0,
        PH_AVOID   = 2'd1,
        PH_RECOVER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_REWIND  = 2'd2,
        ACT_RESEND  = 2'd3
    } t_action;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACK1,
        S_TMO,
        S_CMP_OLD,
        S_CMP_NEXT,
        S_CMP_LAST,
        S_AVOID_CMP,
        S_ADD_WIN,
        S_CLAMP,
        S_CMP_THR,
        S_OUT
    } t_state;

    typedef struct packed {
        t_alu_op            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]   res;
        logic               lt;
        logic               eq;
    } t_alu_rsp;

endpackage

>>> hdl/rcwc_if.sv
// Handshake channels of the Reno congestion window control core:
// event input, result output and configuration write. Depends on rcwc_pkg.
interface rcwc_ev_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [rcwc_pkg::SEQ_W-1:0]  ack_number;
    logic [rcwc_pkg::SEQ_W-1:0]  acked_sequence;
    logic                        selective_flag;
    logic                        window_empty;
    logic [rcwc_pkg::SEQ_W-1:0]  oldest_unacked;
    logic [rcwc_pkg::SEQ_W-1:0]  next_seq;

    modport source (output valid, operation, ack_number, acked_sequence, selective_flag,
                    window_empty, oldest_unacked, next_seq, input ready);
    modport sink   (input valid, operation, ack_number, acked_sequence, selective_flag,
                    window_empty, oldest_unacked, next_seq, output ready);
endinterface

interface rcwc_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [rcwc_pkg::SEQ_W-1:0]  target_seq;
    logic [rcwc_pkg::WIN_W-1:0]  window;
    logic [rcwc_pkg::WIN_W-1:0]  threshold;
    logic [1:0]                  phase;

    modport source (output valid, action, target_seq, window, threshold, phase,
                    input ready);
    modport sink   (input valid, action, target_seq, window, threshold, phase,
                    output ready);
endinterface

interface rcwc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rcwc_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [rcwc_pkg::WIN_W-1:0]      wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> hdl/rcwc_alu.sv
// Shared add/subtract/compare unit of the Reno congestion window control core.
// One carry chain serves every add and every magnitude compare. Depends on rcwc_pkg.
module rcwc_alu (
    input  rcwc_pkg::t_alu_req  i_req,
    output rcwc_pkg::t_alu_rsp  o_rsp
);

    logic [rcwc_pkg::ALU_W-1:0] w_b_eff;
    logic [rcwc_pkg::ALU_W:0]   w_sum;
    logic                       w_sub;

    assign w_sub   = (i_req.op == rcwc_pkg::ALU_SUB);
    assign w_b_eff = w_sub ? ~i_req.b : i_req.b;
    assign w_sum   = {1'b0, i_req.a} + {1'b0, w_b_eff}
                   + {{rcwc_pkg::ALU_W{1'b0}}, w_sub};

    // On subtract, no carry out means a borrow: a < b
    assign o_rsp.res = w_sum[rcwc_pkg::ALU_W-1:0];
    assign o_rsp.lt  = ~w_sum[rcwc_pkg::ALU_W];
    assign o_rsp.eq  = (w_sum[rcwc_pkg::ALU_W-1:0] == '0);

endmodule

>>> hdl/reno_congestion_window_control_core.sv
// Reno congestion window control core: one ACK or timeout event per request.
// The sequencer steps each compare and add through the single shared ALU, so a request is
// taken only when the previous one has left the sequencer.
// The result sits in an output register, so the next request is taken while it waits.
// Reset (i_rst_n low, synchronous) loads slow start, window 1, threshold 128,
// max window 16384, clears the duplicate count and invalidates the last ACK.
module reno_congestion_window_control_core #(
    parameter int unsigned DUP_ACK_LIMIT = rcwc_pkg::DUP_ACK_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rcwc_cfg_if.sink       i_cfg,
    rcwc_ev_if.sink        i_ev,
    rcwc_res_if.source     o_res
);

    `include "reno_congestion_window_control_core_assert.svh"

    localparam int unsigned DUP_W = $clog2(DUP_ACK_LIMIT + 1);

    // ---------------------------------------------------------------
    // Configuration and block state
    // ---------------------------------------------------------------
    logic [rcwc_pkg::WIN_W-1:0]   r_max;
    rcwc_pkg::t_phase             r_phase;
    logic [rcwc_pkg::WIN_W-1:0]   r_window;
    logic [rcwc_pkg::WIN_W-1:0]   r_thr;
    logic [rcwc_pkg::AVOID_W-1:0] r_avoid;
    logic                         r_last_valid;
    logic [rcwc_pkg::SEQ_W-1:0]   r_last;
    logic [DUP_W-1:0]             r_dup;

    // Captured request
    logic                         r_op;
    logic [rcwc_pkg::SEQ_W-1:0]   r_ack;
    logic [rcwc_pkg::SEQ_W-1:0]   r_acked;
    logic                         r_sel;
    logic                         r_empty;
    logic [rcwc_pkg::SEQ_W-1:0]   r_oldest;
    logic [rcwc_pkg::SEQ_W-1:0]   r_next;

    // Sequencer scratch
    rcwc_pkg::t_state             r_state;
    rcwc_pkg::t_state             n_state;
    logic [rcwc_pkg::ALU_W-1:0]   r_ack1;
    logic                         r_eqold;
    logic                         r_add_thr;
    logic [1:0]                   r_add_k;
    logic [rcwc_pkg::WIN_W:0]     r_vwin;
    logic                         r_chk_thr;
    rcwc_pkg::t_action            r_action;
    logic [rcwc_pkg::SEQ_W-1:0]   r_target;

    // Output register
    logic                         r_o_valid;
    rcwc_pkg::t_action            r_o_action;
    logic [rcwc_pkg::SEQ_W-1:0]   r_o_target;
    logic [rcwc_pkg::WIN_W-1:0]   r_o_window;
    logic [rcwc_pkg::WIN_W-1:0]   r_o_thr;
    rcwc_pkg::t_phase             r_o_phase;

    rcwc_pkg::t_alu_req           w_alu_req;
    rcwc_pkg::t_alu_rsp           w_alu_rsp;

    logic                         w_ev_take;
    logic                         w_cfg_take;
    logic                         w_out_load;
    logic [rcwc_pkg::WIN_W-1:0]   w_lim;
    logic                         w_is_dup;
    logic [DUP_W-1:0]             w_dup_inc;
    logic                         w_dup_hit;

    rcwc_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // Accept a request or a register write only when the sequencer rests
    assign i_ev.ready  = (r_state == rcwc_pkg::S_IDLE);
    assign i_cfg.ready = (r_state == rcwc_pkg::S_IDLE);
    assign w_ev_take   = i_ev.valid & i_ev.ready;
    assign w_cfg_take  = i_cfg.valid & i_cfg.ready;
    assign w_out_load  = (r_state == rcwc_pkg::S_OUT) & (~r_o_valid | o_res.ready);

    // A zero max window behaves as one
    assign w_lim = (r_max == '0) ? rcwc_pkg::WIN_W'(1) : r_max;

    // Duplicate: ACK sits at the window start (or nothing outstanding) and repeats last ACK
    assign w_is_dup  = (r_empty | r_eqold) & r_last_valid & w_alu_rsp.eq;
    assign w_dup_inc = r_dup + DUP_W'(1);
    assign w_dup_hit = (w_dup_inc >= DUP_W'(DUP_ACK_LIMIT));

    // ---------------------------------------------------------------
    // Sequencer: state register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcwc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state and ALU operand selection
    // ---------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        w_alu_req.op  = rcwc_pkg::ALU_SUB;
        w_alu_req.a   = '0;
        w_alu_req.b   = '0;
        case (r_state)
            rcwc_pkg::S_IDLE: begin
                if (w_ev_take) begin
                    n_state = rcwc_pkg::S_ACK1;
                end
            end
            rcwc_pkg::S_ACK1: begin
                // ack + 1 at full 33 bits, no wrap
                w_alu_req.op = rcwc_pkg::ALU_ADD;
                w_alu_req.a  = rcwc_pkg::ALU_W'(r_ack);
                w_alu_req.b  = rcwc_pkg::ALU_W'(1);
                n_state = (r_op == rcwc_pkg::OP_TIMEOUT) ? rcwc_pkg::S_TMO
                                                        : rcwc_pkg::S_CMP_OLD;
            end
            rcwc_pkg::S_TMO: begin
                w_alu_req.a = rcwc_pkg::ALU_W'(r_oldest);
                w_alu_req.b = rcwc_pkg::ALU_W'(1);
                n_state = rcwc_pkg::S_OUT;
            end
            rcwc_pkg::S_CMP_OLD: begin
                w_alu_req.a = r_ack1;
                w_alu_req.b = rcwc_pkg::ALU_W'(r_oldest);
                n_state = (!r_empty && w_alu_rsp.lt) ? rcwc_pkg::S_OUT
                                                     : rcwc_pkg::S_CMP_NEXT;
            end
            rcwc_pkg::S_CMP_NEXT: begin
                w_alu_req.a = rcwc_pkg::ALU_W'(r_next);
                w_alu_req.b = r_ack1;
                n_state = (!r_empty && w_alu_rsp.lt) ? rcwc_pkg::S_OUT
                                                     : rcwc_pkg::S_CMP_LAST;
            end
            rcwc_pkg::S_CMP_LAST: begin
                w_alu_req.a = rcwc_pkg::ALU_W'(r_ack);
                w_alu_req.b = rcwc_pkg::ALU_W'(r_last);
                if (w_is_dup) begin
                    n_state = w_dup_hit ? rcwc_pkg::S_ADD_WIN : rcwc_pkg::S_OUT;
                end else if (r_phase == rcwc_pkg::PH_AVOID) begin
                    n_state = rcwc_pkg::S_AVOID_CMP;
                end else begin
                    n_state = rcwc_pkg::S_ADD_WIN;
                end
            end
            rcwc_pkg::S_AVOID_CMP: begin
                w_alu_req.a = rcwc_pkg::ALU_W'(r_avoid);
                w_alu_req.b = rcwc_pkg::ALU_W'({r_window, 2'b00});
                n_state = w_alu_rsp.lt ? rcwc_pkg::S_CMP_THR : rcwc_pkg::S_ADD_WIN;
            end
            rcwc_pkg::S_ADD_WIN: begin
                w_alu_req.op = rcwc_pkg::ALU_ADD;
                w_alu_req.a  = rcwc_pkg::ALU_W'(r_add_thr ? r_thr : r_window);
                w_alu_req.b  = rcwc_pkg::ALU_W'(r_add_k);
                n_state = rcwc_pkg::S_CLAMP;
            end
            rcwc_pkg::S_CLAMP: begin
                w_alu_req.a = rcwc_pkg::ALU_W'(r_vwin);
                w_alu_req.b = rcwc_pkg::ALU_W'(w_lim);
                n_state = r_chk_thr ? rcwc_pkg::S_CMP_THR : rcwc_pkg::S_OUT;
            end
            rcwc_pkg::S_CMP_THR: begin
                w_alu_req.a = rcwc_pkg::ALU_W'(r_window);
                w_alu_req.b = rcwc_pkg::ALU_W'(r_thr);
                n_state = rcwc_pkg::S_OUT;
            end
            rcwc_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = rcwc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcwc_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Captured request and scratch (payload, no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_ev_take) begin
            r_op     <= i_ev.operation;
            r_ack    <= i_ev.ack_number;
            r_acked  <= i_ev.acked_sequence;
            r_sel    <= i_ev.selective_flag;
            r_empty  <= i_ev.window_empty;
            r_oldest <= i_ev.oldest_unacked;
            r_next   <= i_ev.next_seq;
        end
        case (r_state)
            rcwc_pkg::S_ACK1: begin
                r_ack1 <= w_alu_rsp.res;
            end
            rcwc_pkg::S_TMO: begin
                // Rewind to the packet before the oldest; wrap at 32 bits
                r_action <= r_empty ? rcwc_pkg::ACT_NONE : rcwc_pkg::ACT_REWIND;
                r_target <= r_empty ? '0 : w_alu_rsp.res[rcwc_pkg::SEQ_W-1:0];
            end
            rcwc_pkg::S_CMP_OLD: begin
                r_eqold  <= w_alu_rsp.eq;
                // Stale ACK: drop with no action
                r_action <= rcwc_pkg::ACT_NONE;
                r_target <= '0;
            end
            rcwc_pkg::S_CMP_NEXT: begin
                // ACK at or beyond next_seq: rewind to the ACK number
                r_action <= rcwc_pkg::ACT_REWIND;
                r_target <= r_ack;
            end
            rcwc_pkg::S_CMP_LAST: begin
                // Limit hit outside recovery inflates from the halved threshold by three;
                // a new ACK in recovery restarts from threshold + 1
                r_add_k   <= (w_is_dup && w_dup_hit && r_phase != rcwc_pkg::PH_RECOVER)
                             ? rcwc_pkg::INC_THREE : rcwc_pkg::INC_ONE;
                r_add_thr <= w_is_dup ? (w_dup_hit && r_phase != rcwc_pkg::PH_RECOVER)
                                      : (r_phase == rcwc_pkg::PH_RECOVER);
                r_chk_thr <= ~w_is_dup;
                if (w_is_dup) begin
                    if (!w_dup_hit) begin
                        r_action <= rcwc_pkg::ACT_NONE;
                        r_target <= '0;
                    end else if (!r_sel) begin
                        r_action <= rcwc_pkg::ACT_REWIND;
                        r_target <= r_ack;
                    end else if (!r_empty) begin
                        r_action <= rcwc_pkg::ACT_RESEND;
                        r_target <= r_oldest;
                    end else begin
                        r_action <= rcwc_pkg::ACT_NONE;
                        r_target <= '0;
                    end
                end else begin
                    r_action <= rcwc_pkg::ACT_RELEASE;
                    r_target <= r_acked;
                end
            end
            rcwc_pkg::S_ADD_WIN: begin
                r_vwin <= w_alu_rsp.res[rcwc_pkg::WIN_W:0];
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Congestion state and configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= rcwc_pkg::MAX_WINDOW_RST;
            r_phase      <= rcwc_pkg::PH_SLOW;
            r_window     <= rcwc_pkg::WIN_W'(1);
            r_thr        <= rcwc_pkg::INIT_THR_RST;
            r_avoid      <= '0;
            r_last_valid <= 1'b0;
            r_dup        <= '0;
        end else begin
            case (r_state)
                rcwc_pkg::S_TMO: begin
                    // Timeout: back to slow start, threshold to half the window
                    r_phase  <= rcwc_pkg::PH_SLOW;
                    r_thr    <= r_window >> 1;
                    r_window <= rcwc_pkg::WIN_W'(1);
                end
                rcwc_pkg::S_CMP_LAST: begin
                    if (w_is_dup) begin
                        if (w_dup_hit) begin
                            r_dup        <= '0;
                            r_last_valid <= 1'b0;
                            if (r_phase != rcwc_pkg::PH_RECOVER) begin
                                r_thr   <= r_window >> 1;
                                r_phase <= rcwc_pkg::PH_RECOVER;
                            end
                        end else begin
                            r_dup <= w_dup_inc;
                        end
                    end else begin
                        r_dup        <= '0;
                        r_last_valid <= 1'b1;
                        r_last       <= r_ack;
                        if (r_phase == rcwc_pkg::PH_AVOID) begin
                            r_avoid <= r_avoid + rcwc_pkg::AVOID_W'(1);
                        end else begin
                            r_avoid <= '0;
                        end
                        if (r_phase == rcwc_pkg::PH_RECOVER) begin
                            r_phase <= rcwc_pkg::PH_AVOID;
                        end
                    end
                end
                rcwc_pkg::S_AVOID_CMP: begin
                    // Window grows by one per 4 * window new ACKs
                    if (!w_alu_rsp.lt) begin
                        r_avoid <= '0;
                    end
                end
                rcwc_pkg::S_CLAMP: begin
                    r_window <= w_alu_rsp.lt ? r_vwin[rcwc_pkg::WIN_W-1:0] : w_lim;
                end
                rcwc_pkg::S_CMP_THR: begin
                    if (!w_alu_rsp.lt) begin
                        r_phase <= rcwc_pkg::PH_AVOID;
                    end
                end
                default: begin
                end
            endcase
            // Config arrives only while idle; a threshold write also reloads the threshold
            if (w_cfg_take) begin
                case (i_cfg.reg_index)
                    rcwc_pkg::CFG_MAX_WINDOW: begin
                        r_max <= i_cfg.wr_data;
                    end
                    rcwc_pkg::CFG_INIT_THR: begin
                        r_thr <= i_cfg.wr_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold the result until taken
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_action <= r_action;
            r_o_target <= r_target;
            r_o_window <= r_window;
            r_o_thr    <= r_thr;
            r_o_phase  <= r_phase;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.action     = r_o_action;
    assign o_res.target_seq = r_o_target;
    assign o_res.window     = r_o_window;
    assign o_res.threshold  = r_o_thr;
    assign o_res.phase      = r_o_phase;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `RCWC_ASSERT(a_none_zero_target, (r_o_valid && r_o_action == rcwc_pkg::ACT_NONE) |-> (r_o_target == '0), "no-action result carries a nonzero target")
    `RCWC_ASSERT(a_dup_below_limit, (r_state == rcwc_pkg::S_IDLE) |-> (r_dup < DUP_W'(DUP_ACK_LIMIT)), "duplicate count at rest reached the limit")
    `RCWC_ASSERT(a_release_tracks_ack, (r_state == rcwc_pkg::S_OUT && r_action == rcwc_pkg::ACT_RELEASE) |-> (r_last_valid && r_dup == '0), "release without a recorded new ACK")
    `RCWC_ASSERT(a_window_nonzero, (r_state == rcwc_pkg::S_OUT) |-> (r_window != '0), "congestion window dropped to zero")

endmodule
